// ===== rtl/core/cubic_bezier_plane_evaluator_core_assert.svh =====
// Assertion macros shared by the cubic Bezier evaluator core.
// Depends on nothing; the includer supplies the clock and reset names.
`ifndef CUBIC_BEZIER_PLANE_EVALUATOR_CORE_ASSERT_SVH
`define CUBIC_BEZIER_PLANE_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check on a given clock and reset
`define CBPE_ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// check on clk and rst
`define CBPE_ASSERT(label, prop, msg) \
  `CBPE_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define CBPE_ASSERT_CLK(label, ck, rs, prop, msg)
`define CBPE_ASSERT(label, prop, msg)
`endif
`endif

// ===== rtl/core/cbpe_pkg.sv =====
// Package of the cubic Bezier evaluator: payload types and constants.
// Used by the normalization step and the top level.
package cbpe_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [14:0] DIR_ONE = 15'd16384;
  // top bit of the 15-bit quotient: set only when q equals one
  localparam int DIR_TOP = 14;

  typedef struct packed {
    logic [16:0] curve_param;
  } param_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
    logic               dir_valid;
  } result_t;

  // state carried through the digit-recurrence stages
  typedef struct packed {
    logic [14:0]        qx;
    logic [14:0]        qz;
    logic signed [67:0] kx;
    logic signed [67:0] kz;
    logic signed [67:0] lx;
    logic signed [67:0] lz;
    logic [32:0]        sum;
    logic [61:0]        rhsx;
    logic [61:0]        rhsz;
    logic signed [31:0] posx;
    logic signed [31:0] posz;
    logic               negx;
    logic               negz;
    logic               nz;
  } norm_t;

endpackage

// ===== rtl/core/cbpe_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Does not import cbpe_pkg; the payload type is a parameter.
interface cbpe_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cbpe_norm_step.sv =====
// One bit of the unit-length quotient for both axes, one register stage.
// Depends on cbpe_pkg (norm_t).
module cbpe_norm_step
  import cbpe_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  src_valid,
  input  norm_t src,
  output logic  dst_valid,
  output norm_t dst
);

  // K = (2q-1)^2 * S, L = (2q-1) * S; candidate q | 2^BIT
  function automatic logic signed [67:0] cand_f(input logic signed [67:0] k,
                                                input logic signed [67:0] l,
                                                input logic signed [67:0] s);
    cand_f = k + (l <<< (BIT + 2)) + (s <<< (2 * BIT + 2));
  endfunction

  logic signed [67:0] s_ext;
  logic signed [67:0] cand_x;
  logic signed [67:0] cand_z;
  logic               take_x;
  logic               take_z;
  norm_t              dst_next;

  always_comb begin
    s_ext = $signed({35'd0, src.sum});
    cand_x = cand_f(src.kx, src.lx, s_ext);
    cand_z = cand_f(src.kz, src.lz, s_ext);
    take_x = !src.qx[DIR_TOP] && (cand_x <= $signed({6'd0, src.rhsx}));
    take_z = !src.qz[DIR_TOP] && (cand_z <= $signed({6'd0, src.rhsz}));
    dst_next = src;
    if (take_x) begin
      dst_next.qx = src.qx | (15'd1 << BIT);
      dst_next.kx = cand_x;
      dst_next.lx = src.lx + (s_ext <<< (BIT + 1));
    end
    if (take_z) begin
      dst_next.qz = src.qz | (15'd1 << BIT);
      dst_next.kz = cand_z;
      dst_next.lz = src.lz + (s_ext <<< (BIT + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en) begin
      dst_valid <= src_valid;
    end
    if (en) begin
      dst <= dst_next;
    end
  end

endmodule

// ===== rtl/core/cubic_bezier_plane_evaluator_core.sv =====
// Cubic Bezier evaluator in the x-z plane: position and unit tangent.
// Throughput: one item per cycle while the output is ready; 15 quotient stages set the depth.
// Each stage holds its item only while the next one is full and stalled.
// Synchronous reset clears all valid bits and the control points to zero.
// Depends on cbpe_pkg, cbpe_stream_if, cbpe_norm_step and the assert header.
`include "cubic_bezier_plane_evaluator_core_assert.svh"
module cubic_bezier_plane_evaluator_core
  import cbpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [REG_IDX_W-1:0]   wr_index,
  input  logic [31:0]            wr_data,
  cbpe_stream_if.sink            tparam,
  cbpe_stream_if.source          curve
);

  localparam int LAST = 26;

  // control points, [axis][point], axis 0 = x, 1 = z
  logic signed [31:0] pt [2][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 4; i++) begin
          pt[a][i] <= '0;
        end
      end
    end else if (wr_en) begin
      pt[wr_index[0]][wr_index[2:1]] <= $signed(wr_data);
    end
  end

  // stage valids and load enables
  logic [10:1]   vr;
  logic [25:11]  vn;
  logic          v26;
  logic [LAST:1] v;
  logic [LAST:1] en;

  always_comb begin
    v = {v26, vn, vr};
    en[LAST] = !v[LAST] || curve.ready;
    for (int i = LAST - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i + 1];
    end
  end

  assign tparam.ready = en[1];

  // stage registers
  logic [16:0]        s1_t, s2_t, s3_t, s4_t, s5_t;
  logic signed [50:0] s2_m [2][3];
  logic signed [31:0] s3_q [2][3];
  logic signed [31:0] s4_q [2][2];
  logic signed [50:0] s4_m [2][2];
  logic signed [31:0] s5_r [2][2];
  logic signed [31:0] s6_r0 [2];
  logic signed [50:0] s6_m [2];
  logic signed [32:0] s6_d [2];
  logic signed [31:0] s7_pos [2];
  logic [31:0]        s7_mag [2];
  logic               s7_neg [2];
  logic signed [31:0] s8_pos [2];
  logic [15:0]        s8_m [2];
  logic               s8_neg [2];
  logic               s8_nz;
  logic signed [31:0] s9_pos [2];
  logic [31:0]        s9_sq [2];
  logic               s9_neg [2];
  logic               s9_nz;
  norm_t              s10_nd;
  norm_t              nd [10:25];
  result_t            s26;

  // normalizing shift for the tangent magnitudes
  logic [31:0] mmax;
  logic [4:0]  hi;
  logic [4:0]  shamt;

  always_comb begin
    mmax = (s7_mag[0] > s7_mag[1]) ? s7_mag[0] : s7_mag[1];
    hi = '0;
    for (int i = 0; i < 32; i++) begin
      if (mmax[i]) begin
        hi = 5'(i);
      end
    end
    shamt = (hi >= 5'd16) ? hi - 5'd15 : 5'd0;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
      v26 <= 1'b0;
    end else begin
      if (en[1]) begin
        vr[1] <= tparam.valid;
      end
      for (int i = 2; i <= 10; i++) begin
        if (en[i]) begin
          vr[i] <= v[i - 1];
        end
      end
      if (en[LAST]) begin
        v26 <= v[LAST - 1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // saturate t to one
    if (en[1]) begin
      s1_t <= (tparam.data.curve_param > T_ONE) ? T_ONE : tparam.data.curve_param;
    end
    // first lerp level: products
    if (en[2]) begin
      s2_t <= s1_t;
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s2_m[a][i] <= 51'(($signed({pt[a][i + 1][31], pt[a][i + 1]})
                           - $signed({pt[a][i][31], pt[a][i]}))
                          * $signed({1'b0, s1_t}));
        end
      end
    end
    // first lerp level: floor add
    if (en[3]) begin
      s3_t <= s2_t;
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s3_q[a][i] <= pt[a][i] + 32'(s2_m[a][i] >>> 16);
        end
      end
    end
    // second lerp level: products
    if (en[4]) begin
      s4_t <= s3_t;
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < 2; j++) begin
          s4_q[a][j] <= s3_q[a][j];
          s4_m[a][j] <= 51'(($signed({s3_q[a][j + 1][31], s3_q[a][j + 1]})
                           - $signed({s3_q[a][j][31], s3_q[a][j]}))
                          * $signed({1'b0, s3_t}));
        end
      end
    end
    // second lerp level: floor add
    if (en[5]) begin
      s5_t <= s4_t;
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < 2; j++) begin
          s5_r[a][j] <= s4_q[a][j] + 32'(s4_m[a][j] >>> 16);
        end
      end
    end
    // third level product and tangent
    if (en[6]) begin
      for (int a = 0; a < 2; a++) begin
        s6_r0[a] <= s5_r[a][0];
        s6_d[a] <= $signed({s5_r[a][1][31], s5_r[a][1]})
                   - $signed({s5_r[a][0][31], s5_r[a][0]});
        s6_m[a] <= 51'(($signed({s5_r[a][1][31], s5_r[a][1]})
                        - $signed({s5_r[a][0][31], s5_r[a][0]}))
                       * $signed({1'b0, s5_t}));
      end
    end
    // position and tangent magnitude
    if (en[7]) begin
      for (int a = 0; a < 2; a++) begin
        s7_pos[a] <= s6_r0[a] + 32'(s6_m[a] >>> 16);
        s7_neg[a] <= s6_d[a][32];
        s7_mag[a] <= s6_d[a][32] ? 32'(-s6_d[a]) : 32'(s6_d[a]);
      end
    end
    // scale magnitudes below 2^16
    if (en[8]) begin
      s8_nz <= (mmax != 32'd0);
      for (int a = 0; a < 2; a++) begin
        s8_pos[a] <= s7_pos[a];
        s8_neg[a] <= s7_neg[a];
        s8_m[a] <= 16'(s7_mag[a] >> shamt);
      end
    end
    // squares
    if (en[9]) begin
      s9_nz <= s8_nz;
      for (int a = 0; a < 2; a++) begin
        s9_pos[a] <= s8_pos[a];
        s9_neg[a] <= s8_neg[a];
        s9_sq[a] <= s8_m[a] * s8_m[a];
      end
    end
    // seed the quotient recurrence: q = 0, K = S, L = -S
    if (en[10]) begin
      s10_nd.qx <= '0;
      s10_nd.qz <= '0;
      s10_nd.sum <= {1'b0, s9_sq[0]} + {1'b0, s9_sq[1]};
      s10_nd.kx <= $signed({35'd0, {1'b0, s9_sq[0]} + {1'b0, s9_sq[1]}});
      s10_nd.kz <= $signed({35'd0, {1'b0, s9_sq[0]} + {1'b0, s9_sq[1]}});
      s10_nd.lx <= -$signed({35'd0, {1'b0, s9_sq[0]} + {1'b0, s9_sq[1]}});
      s10_nd.lz <= -$signed({35'd0, {1'b0, s9_sq[0]} + {1'b0, s9_sq[1]}});
      s10_nd.rhsx <= {s9_sq[0], 30'd0};
      s10_nd.rhsz <= {s9_sq[1], 30'd0};
      s10_nd.posx <= s9_pos[0];
      s10_nd.posz <= s9_pos[1];
      s10_nd.negx <= s9_neg[0];
      s10_nd.negz <= s9_neg[1];
      s10_nd.nz <= s9_nz;
    end
    // result register: apply signs, zero direction for a zero tangent
    if (en[LAST]) begin
      s26.pos_x <= nd[25].posx;
      s26.pos_z <= nd[25].posz;
      s26.dir_valid <= nd[25].nz;
      if (!nd[25].nz) begin
        s26.dir_x <= '0;
        s26.dir_z <= '0;
      end else begin
        s26.dir_x <= nd[25].negx ? -$signed({1'b0, nd[25].qx})
                                 : $signed({1'b0, nd[25].qx});
        s26.dir_z <= nd[25].negz ? -$signed({1'b0, nd[25].qz})
                                 : $signed({1'b0, nd[25].qz});
      end
    end
  end

  assign nd[10] = s10_nd;

  // quotient bits 14 down to 0, one per stage
  for (genvar i = 11; i <= 25; i++) begin : g_step
    cbpe_norm_step #(.BIT(25 - i)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en[i]),
      .src_valid (v[i - 1]),
      .src       (nd[i - 1]),
      .dst_valid (vn[i]),
      .dst       (nd[i])
    );
  end

  assign curve.valid = v26;
  assign curve.data = s26;

  // checks
  `CBPE_ASSERT(a_accept_enters, tparam.valid && tparam.ready |=> vr[1], "accepted item lost")
  `CBPE_ASSERT(a_result_held, v26 && !curve.ready |=> v26, "stalled result dropped")
  `CBPE_ASSERT(a_zero_dir, v26 && !s26.dir_valid |-> s26.dir_x == 16'sd0 && s26.dir_z == 16'sd0, "zero tangent with direction")
  `CBPE_ASSERT(a_dir_range, v26 |-> s26.dir_x <= 16'sd16384 && s26.dir_x >= -16'sd16384, "dir_x out of range")

endmodule
